/* hdl/dxtd_pkg.sv */
// Shared types, codes and constants of the S3TC texel decoder.
package dxtd_pkg;

  // Format selected by the mode register.
  typedef enum logic [1:0] {
    MODE_DXT1  = 2'd0,
    MODE_DXT1A = 2'd1,
    MODE_DXT3  = 2'd2,
    MODE_DXT5  = 2'd3
  } fmt_mode_t;

  // Meaning of a 2-bit color index.
  typedef enum logic [1:0] {
    CIDX_C0    = 2'd0,
    CIDX_C1    = 2'd1,
    CIDX_MIX_A = 2'd2,
    CIDX_MIX_B = 2'd3
  } cidx_t;

  // How the last stage forms alpha.
  typedef enum logic [1:0] {
    ALPHA_FIXED = 2'd0,
    ALPHA_DIV7  = 2'd1,
    ALPHA_DIV5  = 2'd2
  } alpha_kind_t;

  // DXT5 alpha index codes with a fixed meaning.
  localparam logic [2:0] AIDX_A0   = 3'd0;
  localparam logic [2:0] AIDX_A1   = 3'd1;
  localparam logic [2:0] AIDX_ZERO = 3'd6;
  localparam logic [2:0] AIDX_FULL = 3'd7;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

  // Reciprocal multipliers: floor(n/3) for n < 512, n/7 for n < 5461, n/5 for n < 2730.
  localparam logic [8:0]  DIV3_MUL   = 9'd171;
  localparam int          DIV3_SHIFT = 9;
  localparam logic [11:0] DIV7_MUL   = 12'd2341;
  localparam int          DIV7_SHIFT = 14;
  localparam logic [10:0] DIV5_MUL   = 11'd1639;
  localparam int          DIV5_SHIFT = 13;

  // Stage 1 result: the texel's indices and the block data it needs.
  typedef struct packed {
    logic [15:0] c0;
    logic [15:0] c1;
    cidx_t       csel;
    logic        three_color;
    fmt_mode_t   mode;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [2:0]  asel;
    logic [3:0]  anib;
  } fetch_t;

  // Stage 2 result: final color or numerators that still need a division.
  typedef struct packed {
    logic [15:0] direct;
    logic        div3;
    logic [6:0]  num_r;
    logic [7:0]  num_g;
    logic [6:0]  num_b;
    alpha_kind_t akind;
    logic [10:0] anum;
    logic [7:0]  afixed;
  } blend_t;

endpackage

/* hdl/dxtd_fetch.sv */
// Stage 1: picks the texel's color and alpha indices out of the block.
module dxtd_fetch import dxtd_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  fmt_mode_t   mode,
  input  logic [15:0] color_endpoint_0,
  input  logic [15:0] color_endpoint_1,
  input  logic [31:0] color_indices,
  input  logic [63:0] alpha_part,
  input  logic [1:0]  texel_col,
  input  logic [1:0]  texel_row,
  output fetch_t      q_r
);

  logic [4:0]  cbit;
  logic [5:0]  nbit;
  logic [3:0]  texel;
  logic [5:0]  abit;
  logic [47:0] aidx_word;
  fetch_t      q_nxt;

  // Bit positions of the texel in the index words.
  assign texel     = {texel_row, texel_col};
  assign cbit      = {texel_row, texel_col, 1'b0};
  assign nbit      = {texel_row, texel_col, 2'b00};
  assign abit      = 6'({texel, 1'b0}) + 6'(texel);
  assign aidx_word = alpha_part[63:16];

  always_comb begin
    q_nxt.c0          = color_endpoint_0;
    q_nxt.c1          = color_endpoint_1;
    q_nxt.csel        = cidx_t'(color_indices[cbit +: 2]);
    q_nxt.three_color = (mode == MODE_DXT1 || mode == MODE_DXT1A) &&
                        (color_endpoint_0 <= color_endpoint_1);
    q_nxt.mode        = mode;
    q_nxt.a0          = alpha_part[7:0];
    q_nxt.a1          = alpha_part[15:8];
    q_nxt.asel        = aidx_word[abit +: 3];
    q_nxt.anib        = alpha_part[nbit +: 4];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= q_nxt;
    end
  end

endmodule

/* hdl/dxtd_blend.sv */
// Stage 2: forms direct colors and the numerators of interpolated values.
module dxtd_blend import dxtd_pkg::*; (
  input  logic   clk,
  input  logic   load,
  input  fetch_t d,
  output blend_t q_r
);

  logic [4:0]  r0, r1, b0, b1;
  logic [5:0]  g0, g1;
  logic [5:0]  sum_r, sum_b;
  logic [6:0]  sum_g;
  logic        gt;
  logic [3:0]  w0;
  logic [2:0]  w1;
  logic [10:0] anum;
  blend_t      q_nxt;

  assign r0 = d.c0[15:11];
  assign g0 = d.c0[10:5];
  assign b0 = d.c0[4:0];
  assign r1 = d.c1[15:11];
  assign g1 = d.c1[10:5];
  assign b1 = d.c1[4:0];

  // Plain sums for the three-color midpoint.
  assign sum_r = 6'(r0) + 6'(r1);
  assign sum_g = 7'(g0) + 7'(g1);
  assign sum_b = 6'(b0) + 6'(b1);

  // DXT5 weights: eight-step ramp when a0 > a1, six-step otherwise.
  assign gt   = d.a0 > d.a1;
  assign w0   = gt ? (4'd8 - 4'(d.asel)) : (4'd6 - 4'(d.asel));
  assign w1   = d.asel - 3'd1;
  assign anum = 11'(d.a0) * 11'(w0) + 11'(d.a1) * 11'(w1) + (gt ? 11'd3 : 11'd2);

  // Color: endpoint, midpoint or black directly; otherwise a sum divided by 3 later.
  always_comb begin
    q_nxt.direct = d.c0;
    q_nxt.div3   = 1'b0;
    q_nxt.num_r  = 7'({r0, 1'b0}) + 7'(r1) + 7'd1;
    q_nxt.num_g  = 8'({g0, 1'b0}) + 8'(g1) + 8'd1;
    q_nxt.num_b  = 7'({b0, 1'b0}) + 7'(b1) + 7'd1;
    unique case (d.csel)
      CIDX_C0: q_nxt.direct = d.c0;
      CIDX_C1: q_nxt.direct = d.c1;
      CIDX_MIX_A: begin
        if (d.three_color) begin
          q_nxt.direct = {sum_r[5:1], sum_g[6:1], sum_b[5:1]};
        end else begin
          q_nxt.div3 = 1'b1;
        end
      end
      CIDX_MIX_B: begin
        if (d.three_color) begin
          q_nxt.direct = 16'd0;
        end else begin
          q_nxt.div3  = 1'b1;
          q_nxt.num_r = 7'({r1, 1'b0}) + 7'(r0) + 7'd1;
          q_nxt.num_g = 8'({g1, 1'b0}) + 8'(g0) + 8'd1;
          q_nxt.num_b = 7'({b1, 1'b0}) + 7'(b0) + 7'd1;
        end
      end
      default: q_nxt.direct = d.c0;
    endcase

    // Alpha: fixed values here, interpolated ones as a numerator.
    q_nxt.akind  = ALPHA_FIXED;
    q_nxt.anum   = anum;
    q_nxt.afixed = ALPHA_OPAQUE;
    unique case (d.mode)
      MODE_DXT1: q_nxt.afixed = ALPHA_OPAQUE;
      MODE_DXT1A: begin
        // The transparent black texel of three-color mode.
        if (d.three_color && d.csel == CIDX_MIX_B) begin
          q_nxt.afixed = ALPHA_CLEAR;
        end
      end
      // Scaling a nibble by 17 is the same as repeating it.
      MODE_DXT3: q_nxt.afixed = {d.anib, d.anib};
      MODE_DXT5: begin
        priority if (d.asel == AIDX_A0) begin
          q_nxt.afixed = d.a0;
        end else if (d.asel == AIDX_A1) begin
          q_nxt.afixed = d.a1;
        end else if (gt) begin
          q_nxt.akind = ALPHA_DIV7;
        end else if (d.asel == AIDX_ZERO) begin
          q_nxt.afixed = ALPHA_CLEAR;
        end else if (d.asel == AIDX_FULL) begin
          q_nxt.afixed = ALPHA_OPAQUE;
        end else begin
          q_nxt.akind = ALPHA_DIV5;
        end
      end
      default: q_nxt.afixed = ALPHA_OPAQUE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= q_nxt;
    end
  end

endmodule

/* hdl/dxtd_resolve.sv */
// Stage 3: divides by constants, selects and widens channels to 8 bits.
module dxtd_resolve import dxtd_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  blend_t     d,
  output logic [7:0] red_r,
  output logic [7:0] green_r,
  output logic [7:0] blue_r,
  output logic [7:0] alpha_r
);

  logic [15:0] p_r, p_g, p_b;
  logic [22:0] p7;
  logic [21:0] p5;
  logic [4:0]  r5, b5;
  logic [5:0]  g6;
  logic [7:0]  red_nxt, green_nxt, blue_nxt, alpha_nxt;

  // Division by 3, 7 and 5 through reciprocal multiplication.
  assign p_r = 16'(d.num_r) * 16'(DIV3_MUL);
  assign p_g = 16'(d.num_g) * 16'(DIV3_MUL);
  assign p_b = 16'(d.num_b) * 16'(DIV3_MUL);
  assign p7  = 23'(d.anum) * 23'(DIV7_MUL);
  assign p5  = 22'(d.anum) * 22'(DIV5_MUL);

  always_comb begin
    if (d.div3) begin
      r5 = 5'(p_r >> DIV3_SHIFT);
      g6 = 6'(p_g >> DIV3_SHIFT);
      b5 = 5'(p_b >> DIV3_SHIFT);
    end else begin
      r5 = d.direct[15:11];
      g6 = d.direct[10:5];
      b5 = d.direct[4:0];
    end
  end

  // Widen by repeating the high bits.
  assign red_nxt   = {r5, r5[4:2]};
  assign green_nxt = {g6, g6[5:4]};
  assign blue_nxt  = {b5, b5[4:2]};

  always_comb begin
    unique case (d.akind)
      ALPHA_FIXED: alpha_nxt = d.afixed;
      ALPHA_DIV7:  alpha_nxt = 8'(p7 >> DIV7_SHIFT);
      ALPHA_DIV5:  alpha_nxt = 8'(p5 >> DIV5_SHIFT);
      default:     alpha_nxt = d.afixed;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
    end
  end

endmodule

/* hdl/dxt_texel_decoder.sv */
// S3TC texel decoder top level: mode register, pipeline control and stages.
//
// Decodes one texel of a DXT1, DXT3 or DXT5 block to 8-bit RGBA. The block is a
// three-stage pipeline (index fetch, blend, divide and expand) that accepts one
// item per clock while in_stall is low and passes it through the fetch, blend and
// output registers in turn; the last stage is the output register. A stall on the
// result side holds the pipeline and reaches in_stall only once all three stages
// are full, so bubbles are squeezed out. The mode register is sampled as an item
// enters and should only be written while no item is in flight.
module dxt_texel_decoder import dxtd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_color_endpoint_0,
  input  logic [15:0] in_color_endpoint_1,
  input  logic [31:0] in_color_indices,
  input  logic [63:0] in_alpha_part,
  input  logic [1:0]  in_texel_col,
  input  logic [1:0]  in_texel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha
);

  fmt_mode_t mode_r;
  logic      v1_r, v2_r, v3_r;
  logic      ready1, ready2, ready3;
  fetch_t    fetch_q;
  blend_t    blend_q;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DXT1;
    end else if (cfg_wr_en) begin
      mode_r <= fmt_mode_t'(cfg_wr_data);
    end
  end

  // A stage may load when it is empty or the stage after it moves.
  assign ready3   = !v3_r || !out_stall;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;

  dxtd_fetch u_fetch (
    .clk              (clk),
    .load             (ready1),
    .mode             (mode_r),
    .color_endpoint_0 (in_color_endpoint_0),
    .color_endpoint_1 (in_color_endpoint_1),
    .color_indices    (in_color_indices),
    .alpha_part       (in_alpha_part),
    .texel_col        (in_texel_col),
    .texel_row        (in_texel_row),
    .q_r              (fetch_q)
  );

  dxtd_blend u_blend (
    .clk  (clk),
    .load (ready2),
    .d    (fetch_q),
    .q_r  (blend_q)
  );

  dxtd_resolve u_resolve (
    .clk     (clk),
    .load    (ready3),
    .d       (blend_q),
    .red_r   (out_red),
    .green_r (out_green),
    .blue_r  (out_blue),
    .alpha_r (out_alpha)
  );

  // The input side only stalls when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with an empty pipeline stage");

  // An item in stage 2 that may advance shows up at the output next cycle.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && ready3) |=> out_valid)
    else $error("item lost between blend and output stage");

  // A stalled result keeps its place while the stages behind it stay full.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && out_stall && v2_r) |=> (v2_r && v3_r))
    else $error("pipeline dropped an item during a stall");

endmodule
